### rtl/core/ptsq_pkg.sv
`default_nettype none

package ptsq_pkg;

   // Default depth of the profile store.
   localparam int MaxStepsDefault = 8;

   // Command codes carried on the request channel.
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_BEGIN  = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_WRITE  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STEP_COUNT      = 2'd0;
   localparam logic [1:0] CSR_BAND_HALF_WIDTH = 2'd1;
   localparam logic [1:0] CSR_UPDATE_INTERVAL = 2'd2;

   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 16;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now_ms;
      logic [11:0] temperature_q;
      logic        sensor_fault;
      logic [2:0]  step_slot;
      logic [9:0]  step_temperature;
      logic [31:0] step_hold_ms;
   } req_type;

   typedef struct packed {
      logic       heat_demand;
      logic       sample_ok;
      logic       finished;
      logic [3:0] step_index;
      logic       regulating;
   } rsp_type;

   // One entry of the profile store.
   typedef struct packed {
      logic [9:0]  target;
      logic [31:0] hold_ms;
   } entry_type;

   typedef struct packed {
      logic [3:0]  step_count;
      logic [7:0]  band_half_width;
      logic [15:0] update_interval_ms;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/core/ptsq_ram.sv
`default_nettype none

module ptsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/ptsq_engine.sv
`default_nettype none

module ptsq_engine import ptsq_pkg::*; #(
   parameter int MAX_STEPS = MaxStepsDefault,
   localparam int AddrW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire req_type          req,
   input  wire cfg_type          cfg,
   input  wire entry_type        rd_entry,
   output logic [AddrW-1:0]      rd_addr,
   output logic                  wr_en,
   output logic [AddrW-1:0]      wr_addr,
   output entry_type             wr_entry,
   output rsp_type               result
);

   // Largest step count that can take effect, held in the 4-bit count width.
   localparam logic [3:0] CountCap = 4'((MAX_STEPS > 15) ? 15 : MAX_STEPS);
   localparam logic [6:0] SlotLimit = 7'((MAX_STEPS > 64) ? 64 : MAX_STEPS);

   logic        heater_ff, heater_in;
   logic [3:0]  step_ff, step_in;
   logic        hold_active_ff, hold_active_in;
   logic [31:0] hold_start_ff, hold_start_in;
   logic [31:0] last_update_ff, last_update_in;
   logic        fwd_valid_ff, fwd_valid_in;
   entry_type   fwd_entry_ff;

   entry_type          entry;
   logic [3:0]         eff_count;
   logic               slot_ok;
   logic signed [11:0] band_lo_deg, band_hi_deg;
   logic signed [13:0] band_lo, band_hi, temp_s;
   logic               above, below, in_band, started, ok;
   logic [31:0]        hold_ref;

   // The store read was issued last cycle at the present step; a write to that
   // step in the same cycle is taken from the bypass register instead.
   assign entry = fwd_valid_ff ? fwd_entry_ff : rd_entry;

   assign eff_count = (cfg.step_count > CountCap) ? CountCap : cfg.step_count;
   assign slot_ok   = {4'd0, req.step_slot} < SlotLimit;

   assign band_lo_deg = $signed({2'b00, entry.target}) - $signed({4'd0, cfg.band_half_width});
   assign band_hi_deg = $signed({2'b00, entry.target}) + $signed({4'd0, cfg.band_half_width});
   assign band_lo     = {band_lo_deg, 2'b00};
   assign band_hi     = {band_hi_deg, 2'b00};
   assign temp_s      = $signed({2'b00, req.temperature_q});

   assign above   = temp_s > band_hi;
   assign below   = temp_s < band_lo;
   assign in_band = (temp_s > band_lo) && (temp_s < band_hi);

   always_comb begin
      heater_in      = heater_ff;
      step_in        = step_ff;
      hold_active_in = hold_active_ff;
      hold_start_in  = hold_start_ff;
      last_update_in = last_update_ff;
      started        = 1'b0;
      hold_ref       = hold_start_ff;
      ok             = 1'b0;
      if (accept) begin
         case (req.command)
            CMD_SAMPLE: begin
               if (step_ff >= eff_count) begin
                  ok = 1'b0;
               end else if ((req.now_ms - last_update_ff) < {16'd0, cfg.update_interval_ms}) begin
                  ok = 1'b1;
               end else begin
                  last_update_in = req.now_ms;
                  if (!req.sensor_fault) begin
                     ok = 1'b1;
                     started = !hold_active_ff && in_band;
                     if (started) begin
                        hold_active_in = 1'b1;
                        hold_start_in  = req.now_ms;
                        hold_ref       = req.now_ms;
                     end
                     if (above) begin
                        heater_in = 1'b0;
                     end else if (below) begin
                        heater_in = 1'b1;
                     end else if (hold_active_in &&
                                  ((req.now_ms - hold_ref) >= entry.hold_ms)) begin
                        step_in        = step_ff + 4'd1;
                        hold_active_in = 1'b0;
                     end
                  end
               end
            end
            CMD_BEGIN: begin
               step_in        = 4'd0;
               hold_active_in = 1'b0;
            end
            CMD_STOP: begin
               step_in = eff_count;
            end
            default: begin
            end
         endcase
      end
   end

   assign wr_en             = accept && (req.command == CMD_WRITE) && slot_ok;
   assign wr_addr           = AddrW'(req.step_slot);
   assign wr_entry.target   = req.step_temperature;
   assign wr_entry.hold_ms  = req.step_hold_ms;
   assign rd_addr           = AddrW'(step_in);
   assign fwd_valid_in      = wr_en && ({1'b0, req.step_slot} == step_in);

   assign result.heat_demand = heater_in;
   assign result.sample_ok   = ok;
   assign result.finished    = step_in >= eff_count;
   assign result.step_index  = step_in;
   assign result.regulating  = hold_active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_ff      <= 1'b0;
         step_ff        <= 4'd0;
         hold_active_ff <= 1'b0;
         hold_start_ff  <= 32'd0;
         last_update_ff <= 32'd0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         heater_ff      <= heater_in;
         step_ff        <= step_in;
         hold_active_ff <= hold_active_in;
         hold_start_ff  <= hold_start_in;
         last_update_ff <= last_update_in;
         fwd_valid_ff   <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_entry_ff <= wr_entry;
   end

endmodule

`default_nettype wire

### rtl/core/ptsq_out.sv
`default_nettype none

module ptsq_out import ptsq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   assign take = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (take) begin
         main_valid_in = skid_valid_ff;
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

`default_nettype wire

### rtl/core/profile_thermostat_sequencer_core.sv
`default_nettype none

// Stepped-profile thermostat. Each request beat carries one command (sample,
// begin, stop or write a profile step) and produces exactly one response beat
// with the heater level, the sample status, the finished flag, the step index
// and the regulating flag as they stand after that command. The block takes one
// beat per clock cycle, back to back, while req_stall is low; each response is
// registered and appears the cycle after its request is taken unless an older
// one is stalled. The profile targets and hold times live in a synchronous
// RAM whose read address always follows the current step, so the entry for the
// step in force is ready when the next sample arrives; a write to the current
// step is taken from a bypass register. Nothing in the profile store is cleared
// at reset, so every step must be written before the profile is started. The
// response side has a two-beat buffer: a beat is still taken while one response
// waits, and req_stall rises only once both places are occupied. Configuration
// writes should only be made while no beat is in flight.

module profile_thermostat_sequencer_core import ptsq_pkg::*; #(
   parameter int MAX_STEPS = MaxStepsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0]  csr_wr_data
);

   localparam int AddrW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   // Configuration registers.
   cfg_type   cfg_ff, cfg_in;

   logic      accept;
   logic      out_full;
   rsp_type   result;
   logic      wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   entry_type wr_entry, rd_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_COUNT:      cfg_in.step_count         = csr_wr_data[3:0];
            CSR_BAND_HALF_WIDTH: cfg_in.band_half_width    = csr_wr_data[7:0];
            CSR_UPDATE_INTERVAL: cfg_in.update_interval_ms = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A beat is taken whenever the response buffer has a free place.
   assign req_stall = out_full;
   assign accept    = req_valid && !out_full;

   // Profile store: one entry per step, target and hold time side by side.
   ptsq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_STEPS)
   ) u_profile (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   ptsq_engine #(
      .MAX_STEPS (MAX_STEPS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cfg      (cfg_ff),
      .rd_entry (rd_entry),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .result   (result)
   );

   ptsq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### bench/thermostat_checker.sv
module thermostat_checker
   import ptsq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0]  csr_wr_data,
   output int                        mismatches,
   output int                        pending,
   output int                        beats_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = MaxStepsDefault;

   // Register copies.
   logic [3:0]  step_count_q;
   logic [7:0]  band_q;
   logic [15:0] interval_q;

   // Thermostat state as the block should hold it.
   logic        heater;
   logic        holding;
   logic [3:0]  step_now;
   logic [31:0] hold_began;
   logic [31:0] last_taken;
   logic [9:0]  target_mem [Depth];
   logic [31:0] hold_mem [Depth];

   rsp_type status_queue [$];

   initial begin
      mismatches    = 0;
      pending       = 0;
      beats_checked = 0;
   end

   // Applies one request beat to the state and returns the status it should produce.
   function automatic rsp_type advance_thermostat(req_type beat);
      logic [3:0]  limit;
      logic        ok;
      logic [2:0]  idx;
      logic [31:0] since;
      int          temp;
      int          tgt;
      int          lo;
      int          hi;
      rsp_type     status;
      limit = (step_count_q > Depth) ? 4'(Depth) : step_count_q;
      ok = 1'b0;
      case (beat.command)
         CMD_SAMPLE: begin
            since = beat.now_ms - last_taken;
            if (step_now >= limit) begin
               ok = 1'b0;
            end else if (since < {16'b0, interval_q}) begin
               ok = 1'b1;
            end else begin
               last_taken = beat.now_ms;
               if (!beat.sensor_fault) begin
                  ok   = 1'b1;
                  idx  = step_now[2:0];
                  temp = int'(beat.temperature_q);
                  tgt  = int'(target_mem[idx]);
                  lo   = (tgt - int'(band_q)) * 4;
                  hi   = (tgt + int'(band_q)) * 4;
                  if (!holding && temp > lo && temp < hi) begin
                     holding    = 1'b1;
                     hold_began = beat.now_ms;
                  end
                  if (temp > hi) begin
                     heater = 1'b0;
                  end else if (temp < lo) begin
                     heater = 1'b1;
                  end else if (holding && (beat.now_ms - hold_began) >= hold_mem[idx]) begin
                     step_now = step_now + 4'd1;
                     holding  = 1'b0;
                  end
               end
            end
         end
         CMD_BEGIN: begin
            step_now = 4'd0;
            holding  = 1'b0;
         end
         CMD_STOP: begin
            step_now = limit;
         end
         default: begin
            target_mem[beat.step_slot] = beat.step_temperature;
            hold_mem[beat.step_slot]   = beat.step_hold_ms;
         end
      endcase
      status.heat_demand = heater;
      status.sample_ok   = ok;
      status.finished    = (step_now >= limit);
      status.step_index  = step_now;
      status.regulating  = holding;
      return status;
   endfunction

   task automatic compare_field(string field, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         step_count_q = '0;
         band_q       = '0;
         interval_q   = '0;
         heater       = 1'b0;
         holding      = 1'b0;
         step_now     = '0;
         hold_began   = '0;
         last_taken   = '0;
         for (int i = 0; i < Depth; i++) begin
            target_mem[i] = '0;
            hold_mem[i]   = '0;
         end
         status_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STEP_COUNT:      step_count_q = csr_wr_data[3:0];
               CSR_BAND_HALF_WIDTH: band_q       = csr_wr_data[7:0];
               CSR_UPDATE_INTERVAL: interval_q   = csr_wr_data;
               default: ;
            endcase
         end
         // The response of this edge always belongs to an older request.
         if (rsp_valid && !rsp_stall) begin
            if (status_queue.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response beat %p", $time, rsp_data);
            end else begin
               want = status_queue.pop_front();
               compare_field("heat_demand", want.heat_demand, rsp_data.heat_demand);
               compare_field("sample_ok", want.sample_ok, rsp_data.sample_ok);
               compare_field("finished", want.finished, rsp_data.finished);
               compare_field("step_index", want.step_index, rsp_data.step_index);
               compare_field("regulating", want.regulating, rsp_data.regulating);
               beats_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            status_queue.push_back(advance_thermostat(req_data));
         end
      end
      pending = status_queue.size();
   end

endmodule

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ptsq_pkg::*;

   // Index with no register behind it; writes to it must change nothing.
   localparam logic [CsrIndexW-1:0] CsrSpare = 2'd3;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int WatchdogLimit = 4000;
   localparam int PhaseBeats    = 220;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [CsrIndexW-1:0] csr_index  = '0;
   logic [CsrDataW-1:0] csr_wr_data = '0;

   int mismatches;
   int pending;
   int beats_checked;

   // Flow-control mix of the current phase, in percent.
   int idle_pct  = 0;
   int stall_pct = 0;

   // What the stimulus knows of the settings and profile it has loaded, so that
   // temperatures and times can be aimed at the interesting regions.
   logic [7:0]  cur_band     = '0;
   logic [15:0] cur_interval = '0;
   logic [9:0]  base_target  = 10'd100;
   logic [31:0] wall_ms      = '0;

   int sent         = 0;
   int samples_sent = 0;
   int idle_cycles  = 0;

   always #2 clock = ~clock;

   profile_thermostat_sequencer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   thermostat_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .mismatches    (mismatches),
      .pending       (pending),
      .beats_checked (beats_checked)
   );

   // The receiver stalls at random with the probability of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog: any accepted beat on either channel restarts the count, so only a
   // genuinely stuck block can bring it to the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WatchdogLimit);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // A beat with every field random; callers overwrite the fields they care
   // about, so the unused ones always carry noise.
   function automatic req_type random_beat();
      req_type b;
      b.command          = 2'($urandom);
      b.now_ms           = $urandom;
      b.temperature_q    = 12'($urandom);
      b.sensor_fault     = 1'($urandom);
      b.step_slot        = 3'($urandom);
      b.step_temperature = 10'($urandom);
      b.step_hold_ms     = $urandom;
      return b;
   endfunction

   // Presents one request beat and returns at the edge where it is taken. In
   // the idle phases the sender may first drop valid for a random number of cycles;
   // otherwise valid stays high from one beat to the next.
   task automatic send_beat(req_type item);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sent++;
      if (item.command == CMD_SAMPLE) samples_sent++;
   endtask

   task automatic send_cmd(logic [1:0] cmd, logic [31:0] now, logic [11:0] temp,
                           logic fault);
      req_type b;
      b               = random_beat();
      b.command       = cmd;
      b.now_ms        = now;
      b.temperature_q = temp;
      b.sensor_fault  = fault;
      send_beat(b);
   endtask

   task automatic send_step(logic [2:0] slot, logic [9:0] target, logic [31:0] hold);
      req_type b;
      b                  = random_beat();
      b.command          = CMD_WRITE;
      b.step_slot        = slot;
      b.step_temperature = target;
      b.step_hold_ms     = hold;
      send_beat(b);
   endtask

   // Drops valid, waits until every response has come back and lets the block
   // settle, so that the registers may be rewritten safely.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // The upper data bits of the narrow registers carry noise, which the block
   // must drop.
   task automatic program_registers(logic [3:0] count, logic [7:0] band,
                                    logic [15:0] interval);
      csr_write(CSR_STEP_COUNT, {12'($urandom), count});
      csr_write(CSR_BAND_HALF_WIDTH, {8'($urandom), band});
      csr_write(CSR_UPDATE_INTERVAL, interval);
      cur_band     = band;
      cur_interval = interval;
   endtask

   // Loads all eight steps around one base target. Targets lie up to three
   // degrees above it, so steps may share a band; hold times are mostly a few
   // update intervals long so that the profile really advances.
   task automatic load_profile();
      int tgt;
      logic [31:0] hold;
      base_target = 10'($urandom_range(0, 1023));
      for (int s = 0; s < MaxStepsDefault; s++) begin
         tgt = int'(base_target) + int'($urandom_range(0, 3));
         if (tgt > 1023) tgt = 1023;
         if ($urandom_range(0, 9) == 0) begin
            hold = $urandom;
         end else begin
            hold = 32'($urandom_range(0, 3)) * (32'(cur_interval) + 32'd20)
                   + 32'($urandom_range(0, 20));
         end
         send_step(3'(s), 10'(tgt), hold);
      end
   endtask

   // Picks a temperature below, on, inside or above the band of a step near
   // the base target, or anywhere at all.
   function automatic logic [11:0] pick_temperature();
      int off;
      int lo_edge;
      int hi_edge;
      int temp;
      off     = int'($urandom_range(0, 3));
      lo_edge = (int'(base_target) + off - int'(cur_band)) * 4;
      hi_edge = (int'(base_target) + off + int'(cur_band)) * 4;
      case ($urandom_range(0, 5))
         0:       temp = lo_edge - int'($urandom_range(1, 60));
         1:       temp = lo_edge;
         2:       temp = hi_edge;
         3:       temp = hi_edge + int'($urandom_range(1, 60));
         4:       temp = lo_edge + int'($urandom_range(0, hi_edge - lo_edge));
         default: temp = int'($urandom_range(0, 4095));
      endcase
      if (temp < 0) temp = 0;
      if (temp > 4095) temp = 4095;
      return 12'(temp);
   endfunction

   // A run of samples with time moving on by roughly the update interval. Now
   // and then a sample comes too early, the sensor faults, or a stray begin or
   // stop cuts into the run.
   task automatic sample_burst(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 6) == 0) begin
            wall_ms = wall_ms + 32'($urandom_range(0, cur_interval));
         end else begin
            wall_ms = wall_ms + 32'(cur_interval) + 32'($urandom_range(0, 40));
         end
         k = int'($urandom_range(0, 39));
         if (k == 0) begin
            send_cmd(CMD_STOP, wall_ms, pick_temperature(), 1'($urandom));
         end else if (k == 1) begin
            send_cmd(CMD_BEGIN, wall_ms, pick_temperature(), 1'($urandom));
         end else begin
            send_cmd(CMD_SAMPLE, wall_ms, pick_temperature(),
                     ($urandom_range(0, 11) == 0));
         end
      end
   endtask

   // Random part of one phase. Most of it is whole profile runs (an optional
   // reload, begin, a stretch of samples, perhaps a stop); the rest is sample
   // runs that never saw a begin, and runs of one to four beats of pure noise.
   task automatic run_phase(int quota);
      int goal;
      int roll;
      goal = sent + quota;
      while (sent < goal) begin
         roll = int'($urandom_range(0, 99));
         if (roll < 70) begin
            if ($urandom_range(0, 1) == 1) load_profile();
            if ($urandom_range(0, 3) == 0) wall_ms = $urandom;
            send_cmd(CMD_BEGIN, wall_ms, pick_temperature(), 1'($urandom));
            sample_burst(int'($urandom_range(8, 40)));
            if ($urandom_range(0, 2) == 0) begin
               send_cmd(CMD_STOP, wall_ms, pick_temperature(), 1'($urandom));
            end
         end else if (roll < 85) begin
            sample_burst(int'($urandom_range(2, 10)));
         end else begin
            repeat ($urandom_range(1, 4)) send_beat(random_beat());
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every register written once straight after reset, the unused index too.
      program_registers(4'd0, 8'd0, 16'd0);
      csr_write(CsrSpare, 16'($urandom));

      // With no steps in use the profile is finished, so a sample is refused.
      send_cmd(CMD_SAMPLE, 32'd10, 12'd500, 1'b0);

      // Fill the whole store before anything can read it. Step 0 sits at 100
      // degrees, step 1 at the bottom of the range with no hold time, step 2 at
      // the top with the longest hold possible.
      send_step(3'd0, 10'd100, 32'd300);
      send_step(3'd1, 10'd0, 32'd0);
      send_step(3'd2, 10'd1023, 32'hFFFF_FFFF);
      for (int s = 3; s < MaxStepsDefault; s++) begin
         send_step(3'(s), 10'(100 + s), 32'(s * 50));
      end

      // A step count beyond the store depth counts as the full depth.
      settle();
      program_registers(4'd15, 8'd10, 16'd100);

      send_cmd(CMD_BEGIN, 32'd900, 12'd0, 1'b0);
      // Cold start: the heater comes on.
      send_cmd(CMD_SAMPLE, 32'd1000, 12'd0, 1'b0);
      // Too soon after the last update: ignored but still reported as fine.
      send_cmd(CMD_SAMPLE, 32'd1050, 12'd400, 1'b0);
      // A faulted sample is refused, yet it still moves the update time.
      send_cmd(CMD_SAMPLE, 32'd1100, 12'd400, 1'b1);
      send_cmd(CMD_SAMPLE, 32'd1150, 12'd400, 1'b0);
      // Inside the band: regulation starts here.
      send_cmd(CMD_SAMPLE, 32'd1200, 12'd400, 1'b0);
      // Exactly on the lower, then the upper edge; the hold runs out on the latter.
      send_cmd(CMD_SAMPLE, 32'd1300, 12'd360, 1'b0);
      send_cmd(CMD_SAMPLE, 32'd1500, 12'd440, 1'b0);
      // Step 1: far above the band turns the heater off, then a zero hold
      // advances on the very sample that starts regulation.
      send_cmd(CMD_SAMPLE, 32'd1600, 12'd4095, 1'b0);
      send_cmd(CMD_SAMPLE, 32'd1700, 12'd20, 1'b0);
      // Step 2: the millisecond counter wraps between these two samples.
      send_cmd(CMD_SAMPLE, 32'hFFFF_FFF0, 12'd4095, 1'b0);
      send_cmd(CMD_SAMPLE, 32'h0000_0060, 12'd4095, 1'b0);
      // Stop while regulating, a refused sample, then a fresh begin.
      send_cmd(CMD_STOP, 32'd0, 12'd0, 1'b0);
      send_cmd(CMD_SAMPLE, 32'h0000_0100, 12'd4095, 1'b0);
      send_cmd(CMD_BEGIN, 32'd0, 12'd0, 1'b0);
      wall_ms = 32'h0000_0100;

      // Eight phases, each with its own settings and flow-control mix. The first
      // four cover the extremes of every register; the rest are random.
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         case (phase)
            0:       program_registers(4'd3, 8'd5, 16'd0);
            1:       program_registers(4'd8, 8'd0, 16'hFFFF);
            2:       program_registers(4'd15, 8'd255, 16'd25);
            3:       program_registers(4'd1, 8'd2, 16'd1);
            default: program_registers(4'($urandom_range(1, 15)), 8'($urandom_range(1, 12)),
                                       16'($urandom_range(0, 200)));
         endcase
         case (phase % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 57;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 57;
            end
            default: begin
               idle_pct  = 38;
               stall_pct = 38;
            end
         endcase
         run_phase(PhaseBeats);
      end

      settle();
      repeat (5) @(posedge clock);

      $display("Drove %0d request beats (%0d samples) over eight register settings;",
               sent, samples_sent);
      $display("%0d response beats checked under every mix of sender gaps and stalls.",
               beats_checked);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
